>>> src/flbf_pkg.sv
// Shared types, widths and the Q1.15 coefficient ROM of the low-pass FIR block.
// No dependencies; used by flbf_hist_ram and fir_lowpass_block_filter_unit.
package flbf_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CFG_W    = 9;
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 14;
    localparam int ACC_W    = 34;
    localparam int PROD_W   = COEF_W + SAMPLE_W + 1;
    localparam int ROM_SIZE = 128;
    localparam int ROM_AW   = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 34'sd16384;
    localparam int FRAC_BITS = 15;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 14'sd8191;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -14'sd8192;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_ROM [ROM_SIZE] = '{
        16'sd5, 16'sd10, 16'sd15, 16'sd19, 16'sd22, 16'sd23, 16'sd22, 16'sd18,
        16'sd11, 16'sd0, -16'sd14, -16'sd31, -16'sd48, -16'sd63, -16'sd75,
        -16'sd81, -16'sd77, -16'sd63, -16'sd37, 16'sd0, 16'sd45, 16'sd96,
        16'sd145, 16'sd189, 16'sd219, 16'sd229, 16'sd214, 16'sd171, 16'sd98,
        16'sd0, -16'sd118, -16'sd247, -16'sd373, -16'sd481, -16'sd557,
        -16'sd584, -16'sd550, -16'sd444, -16'sd260, 16'sd0, 16'sd331,
        16'sd719, 16'sd1148, 16'sd1594, 16'sd2032, 16'sd2437, 16'sd2782,
        16'sd3046, 16'sd3212, 16'sd3269, 16'sd3212, 16'sd3046, 16'sd2782,
        16'sd2437, 16'sd2032, 16'sd1594, 16'sd1148, 16'sd719, 16'sd331,
        16'sd0, -16'sd260, -16'sd444, -16'sd550, -16'sd584, -16'sd557,
        -16'sd481, -16'sd373, -16'sd247, -16'sd118, 16'sd0, 16'sd98,
        16'sd171, 16'sd214, 16'sd229, 16'sd219, 16'sd189, 16'sd145, 16'sd96,
        16'sd45, 16'sd0, -16'sd37, -16'sd63, -16'sd77, -16'sd81, -16'sd75,
        -16'sd63, -16'sd48, -16'sd31, -16'sd14, 16'sd0, 16'sd11, 16'sd18,
        16'sd22, 16'sd23, 16'sd22, 16'sd19, 16'sd15, 16'sd10, 16'sd5,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
    };

    function automatic t_coef coef_at(input logic [ROM_AW-1:0] idx);
        return COEF_ROM[idx];
    endfunction

endpackage

>>> src/flbf_hist_ram.sv
// Sample history RAM: one write port, one read port with registered read data.
// Depends on flbf_pkg.
module flbf_hist_ram #(
    parameter int AW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  flbf_pkg::t_sample    i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output flbf_pkg::t_sample    o_rd_data
);

    flbf_pkg::t_sample mem [2**AW];
    flbf_pkg::t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/fir_lowpass_block_filter_unit.sv
// Frame-based low-pass FIR filter, direct form, one shared multiply-accumulate.
// Depends on flbf_pkg and flbf_hist_ram.
//
// Usage:
//   Input beat (i_in_valid/o_in_ready, i_sample): one unsigned 12-bit sample.
//   Output beat (o_out_valid/i_out_ready): o_filtered, rounded and saturated
//   14-bit signed sum of taps; o_block_end marks the last sample of a frame.
//   Config beat (i_cfg_valid/o_cfg_ready, i_cfg_data): frame length, to be
//   written only while idle (the block does not enforce it); 0 acts as 1,
//   values above MAX_BLOCK act as MAX_BLOCK. Samples live in a circular
//   history RAM; taps older than the start of the current frame read as zero,
//   so no clearing pass is ever needed. The single multiplier steps one tap
//   per cycle through the RAM read port, followed by pipeline fill and a
//   round/saturate step before the output is valid. One sample at a time;
//   the next sample is taken while a finished result waits at the output.
//   Reset: frame length 256, frame position 0, no result pending.
//   A stalled receiver holds the result; the block then finishes the next
//   sample and waits before rounding until the output register frees up.
module fir_lowpass_block_filter_unit #(
    parameter int TAPS      = 99,
    parameter int MAX_BLOCK = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [flbf_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [flbf_pkg::OUT_W-1:0] o_filtered,
    output logic                              o_block_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [flbf_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PW  = flbf_pkg::CFG_W;
    localparam int CAP = (MAX_BLOCK < 511) ? MAX_BLOCK : 511;
    localparam logic [PW-1:0] CAP_L = PW'(CAP);
    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state                                r_state;
    logic [PW-1:0]                         r_cfg;
    logic [PW-1:0]                         r_pos;
    logic [AW-1:0]                         r_wp;
    logic [AW-1:0]                         r_issue;
    flbf_pkg::t_sample                     r_x;
    logic                                  r_out_vld;
    logic signed [flbf_pkg::OUT_W-1:0]     r_filtered;
    logic                                  r_block_end;

    logic                                  r_s1_vld;
    logic                                  r_s1_last;
    logic                                  r_s1_live;
    logic [AW-1:0]                         r_s1_tap;
    logic                                  r_s2_vld;
    logic                                  r_s2_last;
    logic signed [flbf_pkg::PROD_W-1:0]    r_prod;
    logic signed [flbf_pkg::ACC_W-1:0]     r_acc;

    logic                                  in_fire;
    logic                                  issuing;
    logic [AW-1:0]                         rd_addr;
    flbf_pkg::t_sample                     rd_data;
    logic [AW-1:0]                         issue_m1;
    logic                                  issue_live;
    flbf_pkg::t_sample                     operand;
    logic [PW-1:0]                         frame_len;
    logic [PW-1:0]                         n_pos;
    logic signed [flbf_pkg::ACC_W-1:0]     rounded;
    logic signed [flbf_pkg::ACC_W-1:0]     shifted;
    logic signed [flbf_pkg::OUT_W-1:0]     sat;
    logic                                  out_free;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign issuing     = (r_state == S_RUN);
    assign issue_m1    = r_issue - 1'b1;
    assign rd_addr     = r_wp - r_issue - 1'b1;
    assign issue_live  = (r_issue == '0) || (PW'(issue_m1) < r_pos);

    flbf_hist_ram #(.AW(AW)) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (in_fire),
        .i_wr_addr (r_wp),
        .i_wr_data (i_sample),
        .i_rd_en   (issuing),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // tap pipeline: issue/read, multiply, accumulate
    always_comb begin
        if (r_s1_tap == '0) begin
            operand = r_x;
        end else if (r_s1_live) begin
            operand = rd_data;
        end else begin
            operand = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= issuing;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_tap  <= r_issue;
        r_s1_last <= (r_issue == LAST_TAP);
        r_s1_live <= issue_live;
        r_s2_last <= r_s1_last;
        r_prod    <= flbf_pkg::PROD_W'(flbf_pkg::coef_at(flbf_pkg::ROM_AW'(r_s1_tap)))
                     * flbf_pkg::PROD_W'($signed({1'b0, operand}));
        if (in_fire) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + flbf_pkg::ACC_W'(r_prod);
        end
    end

    // round half up, floor shift, saturate
    always_comb begin
        rounded = r_acc + flbf_pkg::ROUND_HALF;
        shifted = rounded >>> flbf_pkg::FRAC_BITS;
        if (shifted > flbf_pkg::ACC_W'(flbf_pkg::OUT_MAX)) begin
            sat = flbf_pkg::OUT_MAX;
        end else if (shifted < flbf_pkg::ACC_W'(flbf_pkg::OUT_MIN)) begin
            sat = flbf_pkg::OUT_MIN;
        end else begin
            sat = shifted[flbf_pkg::OUT_W-1:0];
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            frame_len = PW'(1);
        end else if (r_cfg > CAP_L) begin
            frame_len = CAP_L;
        end else begin
            frame_len = r_cfg;
        end
    end

    assign n_pos    = r_pos + 1'b1;
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= flbf_pkg::CFG_RESET;
            r_pos     <= '0;
            r_wp      <= '0;
            r_issue   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_vld && i_out_ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_x     <= i_sample;
                        r_wp    <= r_wp + 1'b1;
                        r_issue <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_issue <= r_issue + 1'b1;
                    if (r_issue == LAST_TAP) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_s2_vld && r_s2_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_filtered <= sat;
                        if (n_pos >= frame_len) begin
                            r_block_end <= 1'b1;
                            r_pos       <= '0;
                        end else begin
                            r_block_end <= 1'b0;
                            r_pos       <= n_pos;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_filtered  = r_filtered;
    assign o_block_end = r_block_end;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for fir_lowpass_block_filter_unit: directed frame and length
// cases, then random sample traffic under sender gaps and receiver stalls.
// Depends on flbf_pkg and the filter RTL; holds its own 99-tap frame predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int NTAPS     = 99;
    localparam int MAX_FRAME = 256;
    localparam int SAT_HI    = 8191;
    localparam int SAT_LO    = -8192;
    localparam int MAX_SMP   = 4095;
    localparam int DRAIN_CYC = 120;

    // first half of the symmetric low-pass impulse response, Q1.15
    localparam int LP_HALF [50] = '{
        5, 10, 15, 19, 22, 23, 22, 18, 11, 0,
        -14, -31, -48, -63, -75, -81, -77, -63, -37, 0,
        45, 96, 145, 189, 219, 229, 214, 171, 98, 0,
        -118, -247, -373, -481, -557, -584, -550, -444, -260, 0,
        331, 719, 1148, 1594, 2032, 2437, 2782, 3046, 3212, 3269
    };

    typedef logic [flbf_pkg::CFG_W-1:0] t_cfg;

    typedef struct {
        logic signed [flbf_pkg::OUT_W-1:0] filtered;
        logic                              block_end;
    } t_filt_out;

    typedef enum {WAVE_NOISE, WAVE_RAILS, WAVE_PEAK_POS, WAVE_PEAK_NEG, WAVE_LEVEL} t_wave;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    flbf_pkg::t_sample                 i_sample;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic signed [flbf_pkg::OUT_W-1:0] o_filtered;
    logic                              o_block_end;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    t_cfg                              i_cfg_data;

    flbf_pkg::t_sample hist [NTAPS-1];
    int                frame_pos;
    t_cfg              frame_len;
    t_filt_out         filtered_due [$];
    t_filt_out         head;
    int                mismatches;
    int                in_idle_pct;
    int                out_stall_pct;

    fir_lowpass_block_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered),
        .o_block_end (o_block_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int tap_weight(input int k);
        return LP_HALF[(k > 49) ? (NTAPS - 1 - k) : k];
    endfunction

    function automatic t_filt_out filter_sample(input flbf_pkg::t_sample s);
        t_filt_out r;
        longint    acc;
        longint    y;
        int        m;
        int        eff_len;
        acc = longint'(tap_weight(0)) * longint'(s);
        for (m = 1; m < NTAPS; m++) begin
            acc += longint'(tap_weight(m)) * longint'(hist[m-1]);
        end
        y = (acc + 16384) >>> 15;
        if (y > SAT_HI) y = SAT_HI;
        if (y < SAT_LO) y = SAT_LO;
        for (m = NTAPS - 2; m >= 1; m--) begin
            hist[m] = hist[m-1];
        end
        hist[0] = s;
        frame_pos++;
        eff_len = (frame_len == 0) ? 1 : ((frame_len > MAX_FRAME) ? MAX_FRAME : frame_len);
        r.block_end = 1'b0;
        if (frame_pos >= eff_len) begin
            r.block_end = 1'b1;
            frame_pos = 0;
            for (m = 0; m < NTAPS - 1; m++) begin
                hist[m] = '0;
            end
        end
        r.filtered = y[flbf_pkg::OUT_W-1:0];
        return r;
    endfunction

    // output beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (filtered_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: filtered=%0d end=%0b", o_filtered, o_block_end);
            end else begin
                head = filtered_due.pop_front();
                if (o_filtered !== head.filtered || o_block_end !== head.block_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp filtered=%0d end=%0b, got filtered=%0d end=%0b",
                                 head.filtered, head.block_end, o_filtered, o_block_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic send_sample(input flbf_pkg::t_sample s);
        int   gap;
        logic taken;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do begin
            @(negedge i_clk);
            taken = o_in_ready;
            @(posedge i_clk);
        end while (!taken);
        filtered_due.push_back(filter_sample(s));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (filtered_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_frame_len(input t_cfg len);
        logic taken;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        frame_len = len;
        @(posedge i_clk);
    endtask

    // reset frame length of 256, field extremes and bit patterns
    task automatic test_reset_frame();
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample('0);
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample(12'h555);
        send_sample(12'hAAA);
        send_sample('0);
        send_sample(12'h800);
    endtask

    task automatic test_frame_lengths();
        write_frame_len('0);            // zero length acts as one
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample(12'h7FF);
        send_sample(12'h001);
        write_frame_len(9'd1);
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample('0);
        write_frame_len('1);            // oversized, clamps to 256
        send_sample(12'hFFF);
        send_sample(12'h0F0);
        write_frame_len(9'd2);
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
        send_sample(12'h3C3);
        write_frame_len(9'd5);
        repeat (4) send_sample(flbf_pkg::t_sample'($urandom_range(MAX_SMP)));
        write_frame_len(9'd3);          // shrink below current position
        send_sample(12'hC3C);
        send_sample(flbf_pkg::t_sample'(MAX_SMP));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
        int                sent;
        int                burst;
        int                k;
        int                level;
        t_wave             wave;
        flbf_pkg::t_sample s;
        flbf_pkg::t_sample top;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        top  = flbf_pkg::t_sample'(MAX_SMP);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(4) != 0) begin
                case ($urandom_range(3))
                    0: write_frame_len(t_cfg'($urandom_range(8)));
                    1: write_frame_len(t_cfg'($urandom_range(MAX_FRAME, NTAPS)));
                    2: write_frame_len(t_cfg'($urandom_range(511, MAX_FRAME + 1)));
                    default: write_frame_len(t_cfg'($urandom_range(NTAPS - 1, 9)));
                endcase
            end else begin
                wait_idle();
            end
            wave  = t_wave'($urandom_range(4));
            level = $urandom_range(MAX_SMP);
            burst = $urandom_range(160, 20);
            for (k = 0; k < burst; k++) begin
                case (wave)
                    WAVE_RAILS:    s = $urandom_range(1) ? top : '0;
                    WAVE_PEAK_POS: s = (tap_weight(frame_pos % NTAPS) > 0) ? top : '0;
                    WAVE_PEAK_NEG: s = (tap_weight(frame_pos % NTAPS) < 0) ? top : '0;
                    WAVE_LEVEL:    s = flbf_pkg::t_sample'(level);
                    default:       s = flbf_pkg::t_sample'($urandom_range(MAX_SMP));
                endcase
                send_sample(s);
            end
            sent += burst;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_sample      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        mismatches    = 0;
        frame_pos     = 0;
        frame_len     = flbf_pkg::CFG_RESET;
        foreach (hist[i]) hist[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_frame();
        test_frame_lengths();
        test_random_traffic(0, 0, 200);
        test_random_traffic(49, 0, 200);
        test_random_traffic(0, 49, 200);
        test_random_traffic(37, 37, 200);
        wait_idle();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
